// ----- hw/rtl/hoc_pkg.sv -----
package hoc_pkg;

  // Table geometry
  localparam int unsigned CAPACITY   = 1024;
  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned KEY_W      = 64;
  localparam int unsigned IDX_W      = $clog2(CAPACITY);
  localparam int unsigned LIVE_W     = $clog2(CAPACITY + 1);
  localparam bit          CAP_POW2   = ((CAPACITY & (CAPACITY - 1)) == 0);

  // Home slot by reciprocal multiplication: floor(2^33 / CAPACITY) and 2^32 mod CAPACITY
  localparam longint unsigned RECIP_M  = 64'h2_0000_0000 / CAPACITY;
  localparam longint unsigned WORD_MOD = 64'h1_0000_0000 % CAPACITY;

  // Result field widths
  localparam int unsigned COUNT_OUT_W   = 16;
  localparam int unsigned ENTRIES_OUT_W = 11;
  localparam int unsigned STATUS_W      = 2;

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [COUNT_BITS-1:0]    cnt_t;
  typedef logic [KEY_W-1:0]         key_t;
  typedef logic [LIVE_W-1:0]        live_t;
  typedef logic [COUNT_OUT_W-1:0]   count_out_t;
  typedef logic [ENTRIES_OUT_W-1:0] entries_out_t;

  typedef enum logic [1:0] {
    ST_EMPTY = 2'd0,
    ST_LIVE  = 2'd1,
    ST_TOMB  = 2'd2
  } slot_st_e;

  typedef enum logic [STATUS_W-1:0] {
    RES_OK        = 2'd0,
    RES_NOT_FOUND = 2'd1,
    RES_FULL      = 2'd2
  } res_st_e;

  typedef enum logic {
    MODE_INC = 1'b0,
    MODE_DEC = 1'b1
  } mode_e;

  typedef struct packed {
    key_t key;
    cnt_t count;
  } slot_entry_t;

  typedef struct packed {
    logic        en;
    idx_t        addr;
    slot_entry_t data;
  } slot_wr_t;

  typedef struct packed {
    logic     en;
    idx_t     addr;
    slot_st_e st;
  } stat_wr_t;

endpackage

// ----- hw/rtl/hashed_occurrence_counter.sv -----
// Occurrence counter for 64-bit keys in a 1024-slot open-addressed table with
// linear probing. Each request carries a key and a mode: increment raises the
// key's count (saturating at all ones) or inserts it with count 1; decrement
// lowers it and turns the slot into a tombstone at zero. Each request returns
// exactly one result: the count after the operation, a status (ok, not found
// on decrement, table full on insert) and the number of live keys. After reset
// the block sweeps the slot-state memory to empty, one slot per cycle, and
// holds in_ready_o low until the sweep is done. A request then goes from
// acceptance through forming the home slot, probing P slots (1 to 1024) in
// turn through the single read port of the slot memories, writing back and
// loading the result register, and an idle state with in_ready_o high, in
// which the next request is taken. With a table size that is not a power of
// two, the home slot is formed as a remainder by reciprocal multiplication
// in two rounds. A finished result waits in its output register while the
// next request is accepted and probed; write-back holds only if that
// register is still occupied.
module hashed_occurrence_counter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         mode_i,
  input  logic [hoc_pkg::KEY_W-1:0]    hash_key_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [hoc_pkg::COUNT_OUT_W-1:0]   count_o,
  output logic [hoc_pkg::STATUS_W-1:0]      status_o,
  output logic [hoc_pkg::ENTRIES_OUT_W-1:0] entries_in_use_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_HASH  = 4'b0010,
    S_PROBE = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Request and probe context
  hoc_pkg::mode_e mode_q, mode_d;
  hoc_pkg::key_t  key_q, key_d;
  hoc_pkg::idx_t  idx_q, idx_d;
  hoc_pkg::idx_t  n_q, n_d;
  logic           tomb_seen_q, tomb_seen_d;
  hoc_pkg::idx_t  tomb_q, tomb_d;
  logic           hit_q, hit_d;
  logic           has_place_q, has_place_d;
  hoc_pkg::idx_t  slot_q, slot_d;
  hoc_pkg::cnt_t  cnt_q, cnt_d;
  hoc_pkg::live_t live_q, live_d;

  // Result register
  logic                  out_valid_q;
  hoc_pkg::count_out_t   count_q;
  hoc_pkg::res_st_e      status_q;
  hoc_pkg::entries_out_t entries_q;

  // Memory ports
  hoc_pkg::slot_wr_t    slot_wr;
  hoc_pkg::stat_wr_t    stat_wr;
  hoc_pkg::idx_t        rd_addr;
  hoc_pkg::slot_entry_t rd_entry;
  hoc_pkg::slot_st_e    rd_st;
  logic                 clear_done;

  // Home slot unit
  logic          home_done;
  hoc_pkg::idx_t home_idx;

  logic             in_fire;
  logic             out_free;
  logic             commit;
  logic             is_last;
  hoc_pkg::idx_t    idx_next;
  hoc_pkg::cnt_t    cnt_inc;
  hoc_pkg::cnt_t    cnt_dec;
  hoc_pkg::cnt_t    res_cnt;
  hoc_pkg::res_st_e res_status;

  assign in_ready_o = (state_q == S_IDLE) && clear_done;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign commit     = (state_q == S_DONE) && out_free;

  assign is_last  = (n_q == hoc_pkg::idx_t'(hoc_pkg::CAPACITY - 1));
  assign idx_next = (idx_q == hoc_pkg::idx_t'(hoc_pkg::CAPACITY - 1))
                    ? '0 : idx_q + hoc_pkg::idx_t'(1);

  // Read the home slot once it is known, then one slot ahead while probing.
  // Writes land only at commit, before the next request can read,
  // so reads never overlap a pending write.
  assign rd_addr = (state_q == S_HASH) ? home_idx : idx_next;

  hoc_home_index u_home_index (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_fire),
    .key_i   (hash_key_i),
    .done_o  (home_done),
    .idx_o   (home_idx)
  );

  hoc_slot_mem u_slot_mem (
    .clk_i     (clk_i),
    .wr_i      (slot_wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_entry)
  );

  hoc_status_mem u_status_mem (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (stat_wr),
    .rd_addr_i    (rd_addr),
    .rd_st_o      (rd_st),
    .clear_done_o (clear_done)
  );

  // Count arithmetic
  assign cnt_inc = (&cnt_q) ? cnt_q : cnt_q + hoc_pkg::cnt_t'(1);
  assign cnt_dec = (cnt_q != '0) ? cnt_q - hoc_pkg::cnt_t'(1) : cnt_q;

  // Result and write-back, taken from the probe outcome
  always_comb begin
    res_cnt      = '0;
    res_status   = hoc_pkg::RES_OK;
    live_d       = live_q;
    slot_wr.en   = 1'b0;
    slot_wr.addr = slot_q;
    slot_wr.data = '{key: key_q, count: cnt_inc};
    stat_wr.en   = 1'b0;
    stat_wr.addr = slot_q;
    stat_wr.st   = hoc_pkg::ST_LIVE;
    if (mode_q == hoc_pkg::MODE_INC) begin
      if (hit_q) begin
        res_cnt    = cnt_inc;
        slot_wr.en = commit;
      end else if (has_place_q) begin
        res_cnt            = hoc_pkg::cnt_t'(1);
        slot_wr.en         = commit;
        slot_wr.data.count = hoc_pkg::cnt_t'(1);
        stat_wr.en         = commit;
        if (commit) begin
          live_d = live_q + hoc_pkg::live_t'(1);
        end
      end else begin
        res_status = hoc_pkg::RES_FULL;
      end
    end else begin
      if (hit_q) begin
        res_cnt            = cnt_dec;
        slot_wr.en         = commit;
        slot_wr.data.count = cnt_dec;
        if (cnt_dec == '0) begin
          stat_wr.en = commit;
          stat_wr.st = hoc_pkg::ST_TOMB;
          if (commit && (live_q != '0)) begin
            live_d = live_q - hoc_pkg::live_t'(1);
          end
        end
      end else begin
        res_status = hoc_pkg::RES_NOT_FOUND;
      end
    end
  end

  // Sequencer: accept, form home slot, probe, commit
  always_comb begin
    logic stop;
    stop        = 1'b0;
    state_d     = state_q;
    mode_d      = mode_q;
    key_d       = key_q;
    idx_d       = idx_q;
    n_d         = n_q;
    tomb_seen_d = tomb_seen_q;
    tomb_d      = tomb_q;
    hit_d       = hit_q;
    has_place_d = has_place_q;
    slot_d      = slot_q;
    cnt_d       = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          mode_d  = hoc_pkg::mode_e'(mode_i);
          key_d   = hash_key_i;
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        if (home_done) begin
          idx_d       = home_idx;
          n_d         = '0;
          tomb_seen_d = 1'b0;
          state_d     = S_PROBE;
        end
      end
      S_PROBE: begin
        case (rd_st)
          hoc_pkg::ST_EMPTY: begin
            stop        = 1'b1;
            hit_d       = 1'b0;
            has_place_d = 1'b1;
            slot_d      = tomb_seen_q ? tomb_q : idx_q;
          end
          hoc_pkg::ST_LIVE: begin
            if (rd_entry.key == key_q) begin
              stop   = 1'b1;
              hit_d  = 1'b1;
              slot_d = idx_q;
              cnt_d  = rd_entry.count;
            end
          end
          hoc_pkg::ST_TOMB: begin
            if (!tomb_seen_q) begin
              tomb_seen_d = 1'b1;
              tomb_d      = idx_q;
            end
          end
          default: begin
          end
        endcase
        if (stop) begin
          state_d = S_DONE;
        end else if (is_last) begin
          // Full loop without a match: reuse the first tombstone, if any
          hit_d       = 1'b0;
          has_place_d = tomb_seen_d;
          slot_d      = tomb_d;
          state_d     = S_DONE;
        end else begin
          idx_d = idx_next;
          n_d   = n_q + hoc_pkg::idx_t'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      live_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      live_q  <= live_d;
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q      <= mode_d;
    key_q       <= key_d;
    idx_q       <= idx_d;
    n_q         <= n_d;
    tomb_seen_q <= tomb_seen_d;
    tomb_q      <= tomb_d;
    hit_q       <= hit_d;
    has_place_q <= has_place_d;
    slot_q      <= slot_d;
    cnt_q       <= cnt_d;
    if (commit) begin
      count_q   <= hoc_pkg::count_out_t'(res_cnt);
      status_q  <= res_status;
      entries_q <= hoc_pkg::entries_out_t'(live_d);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign count_o          = count_q;
  assign status_o         = status_q;
  assign entries_in_use_o = entries_q;

endmodule

// ----- hw/rtl/hoc_home_index.sv -----
module hoc_home_index (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  hoc_pkg::key_t key_i,
  output logic          done_o,
  output hoc_pkg::idx_t idx_o
);

  typedef enum logic [4:0] {
    PH_Q_HI = 5'b00001,
    PH_R_HI = 5'b00010,
    PH_FOLD = 5'b00100,
    PH_Q_LO = 5'b01000,
    PH_R_LO = 5'b10000
  } phase_e;

  if (hoc_pkg::CAP_POW2) begin : g_mask
    logic          done_q;
    hoc_pkg::idx_t idx_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else begin
        done_q <= start_i;
      end
    end

    // Power-of-two capacity: the low key bits are the remainder
    always_ff @(posedge clk_i) begin
      if (start_i) begin
        idx_q <= key_i[hoc_pkg::IDX_W-1:0];
      end
    end

    assign done_o = done_q;
    assign idx_o  = idx_q;
  end else begin : g_recip
    phase_e        ph_q;
    logic          busy_q;
    logic          done_q;
    logic [32:0]   x_q;
    logic [31:0]   lo_q;
    logic [31:0]   q_q;
    hoc_pkg::idx_t rem_q;
    logic [64:0]   prod;
    logic [48:0]   qc;
    logic [32:0]   diff;
    logic [32:0]   rem;
    logic [32:0]   fold;

    // Remainder of a 33-bit operand by reciprocal multiplication. The quotient
    // estimate is low by at most one, so one compare and subtract finishes it.
    // Reduce the upper key word, fold it in as (hi mod C) * (2^32 mod C) + lo,
    // then reduce once more.
    assign prod = {32'b0, x_q} * {33'b0, 32'(hoc_pkg::RECIP_M)};
    assign qc   = {17'b0, q_q} * 49'(hoc_pkg::CAPACITY);
    assign diff = x_q - qc[32:0];
    assign rem  = (diff >= 33'(hoc_pkg::CAPACITY)) ? diff - 33'(hoc_pkg::CAPACITY) : diff;
    assign fold = 33'(x_q[hoc_pkg::IDX_W-1:0]) * 33'(hoc_pkg::WORD_MOD) + {1'b0, lo_q};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        busy_q <= 1'b0;
        done_q <= 1'b0;
        ph_q   <= PH_Q_HI;
      end else begin
        done_q <= 1'b0;
        if (start_i) begin
          busy_q <= 1'b1;
          ph_q   <= PH_Q_HI;
        end else if (busy_q) begin
          case (ph_q)
            PH_Q_HI: ph_q <= PH_R_HI;
            PH_R_HI: ph_q <= PH_FOLD;
            PH_FOLD: ph_q <= PH_Q_LO;
            PH_Q_LO: ph_q <= PH_R_LO;
            PH_R_LO: begin
              busy_q <= 1'b0;
              done_q <= 1'b1;
            end
            default: begin
              busy_q <= 1'b0;
            end
          endcase
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        x_q  <= {1'b0, key_i[hoc_pkg::KEY_W-1:32]};
        lo_q <= key_i[31:0];
      end else if (busy_q) begin
        case (ph_q)
          PH_Q_HI, PH_Q_LO: q_q <= prod[64:33];
          PH_R_HI: x_q <= rem;
          PH_FOLD: x_q <= fold;
          PH_R_LO: rem_q <= rem[hoc_pkg::IDX_W-1:0];
          default: begin
          end
        endcase
      end
    end

    assign done_o = done_q;
    assign idx_o  = rem_q;
  end

endmodule

// ----- hw/rtl/hoc_slot_mem.sv -----
module hoc_slot_mem (
  input  logic                 clk_i,
  input  hoc_pkg::slot_wr_t    wr_i,
  input  hoc_pkg::idx_t        rd_addr_i,
  output hoc_pkg::slot_entry_t rd_data_o
);

  hoc_pkg::slot_entry_t mem_q [hoc_pkg::CAPACITY];
  hoc_pkg::slot_entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- hw/rtl/hoc_status_mem.sv -----
module hoc_status_mem (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hoc_pkg::stat_wr_t wr_i,
  input  hoc_pkg::idx_t     rd_addr_i,
  output hoc_pkg::slot_st_e rd_st_o,
  output logic              clear_done_o
);

  hoc_pkg::slot_st_e mem_q [hoc_pkg::CAPACITY];
  hoc_pkg::slot_st_e rd_st_q;
  logic              clearing_q;
  hoc_pkg::idx_t     clr_q;
  logic              we;
  hoc_pkg::idx_t     waddr;
  hoc_pkg::slot_st_e wdata;

  // Sweep every slot to empty after reset, one per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_q      <= '0;
    end else if (clearing_q) begin
      clr_q <= clr_q + hoc_pkg::idx_t'(1);
      if (clr_q == hoc_pkg::idx_t'(hoc_pkg::CAPACITY - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  assign we    = clearing_q || wr_i.en;
  assign waddr = clearing_q ? clr_q : wr_i.addr;
  assign wdata = clearing_q ? hoc_pkg::ST_EMPTY : wr_i.st;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rd_st_q <= mem_q[rd_addr_i];
  end

  assign rd_st_o      = rd_st_q;
  assign clear_done_o = !clearing_q;

endmodule

// ----- tb/sv/tb_hashed_occurrence_counter.sv -----
`timescale 1ns / 1ps

module tb_hashed_occurrence_counter;
  import hoc_pkg::*;

  localparam int unsigned CLK_HALF     = 5;
  localparam int unsigned RESET_CYCLES = 6;
  // Random requests after the directed table.
  localparam int unsigned RANDOM_ITEMS = 810;
  // Keys drawn from a small colliding set, so that they insert, climb and die often.
  localparam int unsigned HOT_KEYS     = 16;
  // Homes of the fill and hot keys that the random part works on lie in slots 0..HOME_BAND.
  localparam int unsigned HOME_BAND    = 47;
  // One request may probe every slot; wait that long for stray results at the end.
  localparam int unsigned DRAIN_CYCLES = CAPACITY + 76;
  localparam int unsigned TIMEOUT_NS   = 100_000_000;
  localparam int unsigned MAX_REPORTS  = 100;

  // Fill keys have zero low bits, so key FILL_BASE + i has home slot i.
  localparam key_t FILL_BASE = 64'h5A5A_0000_0000_0000;
  localparam key_t KEY_MAX   = '1;

  // What one result carries.
  typedef struct packed {
    count_out_t   count;
    res_st_e      status;
    entries_out_t entries;
  } tally_t;

  // One row of the directed table: a request repeated reps times. With sweep set
  // the key advances by one per repeat. With typed set, count and status are
  // taken from the row; the live-key total always comes from the predictor.
  typedef struct packed {
    mode_e       op;
    key_t        key;
    logic [31:0] reps;
    logic        sweep;
    logic        typed;
    count_out_t  count;
    res_st_e     status;
  } step_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       mode_i      = 1'b0;
  key_t       hash_key_i  = '0;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  count_out_t count_o;
  logic [STATUS_W-1:0] status_o;
  entries_out_t entries_in_use_o;

  // Idle rates in percent of cycles; the stimulus process moves them by phase.
  int unsigned snd_idle_pct = 16;
  int unsigned rcv_idle_pct = 50;
  int unsigned fails = 0;

  // Shadow of the table kept by the predictor.
  key_t     tbl_key   [CAPACITY];
  cnt_t     tbl_count [CAPACITY];
  slot_st_e tbl_state [CAPACITY];
  int unsigned live_keys = 0;

  tally_t awaited_tallies [$];
  step_t  plan [$];
  key_t   hot_keys [HOT_KEYS];

  hashed_occurrence_counter DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .mode_i           (mode_i),
    .hash_key_i       (hash_key_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .count_o          (count_o),
    .status_o         (status_o),
    .entries_in_use_o (entries_in_use_o)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Apply one request to the shadow table and return the result it must give.
  // Probe from the home slot, pass tombstones, stop at the key, at an empty slot
  // or after a full lap. An insert takes the first tombstone passed, else the
  // empty slot where the probe stopped.
  function automatic tally_t count_occurrence(mode_e op, key_t key);
    idx_t        pos;
    idx_t        spot;
    idx_t        tomb_at;
    logic        tomb_seen;
    logic        found;
    logic        has_room;
    int unsigned n;
    tally_t      t;

    pos       = idx_t'(key % CAPACITY);
    spot      = '0;
    tomb_at   = '0;
    tomb_seen = 1'b0;
    found     = 1'b0;
    has_room  = 1'b0;
    for (n = 0; n < CAPACITY; n++) begin
      if (tbl_state[pos] == ST_EMPTY) begin
        has_room = 1'b1;
        spot     = tomb_seen ? tomb_at : pos;
        break;
      end
      if (tbl_state[pos] == ST_LIVE) begin
        if (tbl_key[pos] == key) begin
          found = 1'b1;
          spot  = pos;
          break;
        end
      end else if (!tomb_seen) begin
        tomb_seen = 1'b1;
        tomb_at   = pos;
      end
      pos = (pos == idx_t'(CAPACITY - 1)) ? '0 : pos + 1'b1;
    end
    // A full lap with no empty slot still leaves room in a tombstone.
    if (!found && !has_room && tomb_seen) begin
      has_room = 1'b1;
      spot     = tomb_at;
    end

    t.count  = '0;
    t.status = RES_OK;
    if (op == MODE_INC) begin
      if (found) begin
        // Hold the count at all ones once it gets there.
        if (tbl_count[spot] != {COUNT_BITS{1'b1}}) tbl_count[spot] = tbl_count[spot] + 1'b1;
        t.count = count_out_t'(tbl_count[spot]);
      end else if (has_room) begin
        tbl_key[spot]   = key;
        tbl_count[spot] = cnt_t'(1);
        tbl_state[spot] = ST_LIVE;
        live_keys++;
        t.count = count_out_t'(1);
      end else begin
        t.status = RES_FULL;
      end
    end else begin
      if (found) begin
        if (tbl_count[spot] != '0) tbl_count[spot] = tbl_count[spot] - 1'b1;
        t.count = count_out_t'(tbl_count[spot]);
        // Retire the slot to a tombstone when its count reaches zero.
        if (tbl_count[spot] == '0) begin
          tbl_state[spot] = ST_TOMB;
          if (live_keys > 0) live_keys--;
        end
      end else begin
        t.status = RES_NOT_FOUND;
      end
    end
    t.entries = entries_out_t'(live_keys);
    return t;
  endfunction

  task automatic plan_step(mode_e op, key_t key, int unsigned reps, logic sweep,
                           logic typed, count_out_t count, res_st_e status);
    step_t s;

    s.op     = op;
    s.key    = key;
    s.reps   = reps;
    s.sweep  = sweep;
    s.typed  = typed;
    s.count  = count;
    s.status = status;
    plan.push_back(s);
  endtask

  // Offer one request and hold it until the block takes it. Called just after
  // the rising clock; drop valid only when an idle gap is rolled, so valid is never
  // lowered and raised in the same step.
  task automatic issue(mode_e op, key_t key, logic typed, count_out_t count,
                       res_st_e status);
    tally_t t;

    if ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < snd_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= op;
    hash_key_i <= key;
    do @(posedge clk_i); while (!in_ready_o);
    // Accepted at this edge: advance the shadow table and queue the result.
    t = count_occurrence(op, key);
    if (typed) begin
      t.count  = count;
      t.status = status;
    end
    awaited_tallies.push_back(t);
  endtask

  // Stall the result channel at the current receiver rate.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // Compare each delivered result against the oldest awaited one.
  always @(posedge clk_i) begin : check_result
    tally_t want;

    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_tallies.size() == 0) begin
        if (fails < MAX_REPORTS)
          $error("unexpected result: count %0d status %0d entries %0d",
                 count_o, status_o, entries_in_use_o);
        fails++;
      end else begin
        want = awaited_tallies.pop_front();
        if (count_o !== want.count) begin
          if (fails < MAX_REPORTS)
            $error("count: expected %0d, got %0d", want.count, count_o);
          fails++;
        end
        if (status_o !== want.status) begin
          if (fails < MAX_REPORTS)
            $error("status: expected %0d, got %0d", want.status, status_o);
          fails++;
        end
        if (entries_in_use_o !== want.entries) begin
          if (fails < MAX_REPORTS)
            $error("entries_in_use: expected %0d, got %0d", want.entries,
                   entries_in_use_o);
          fails++;
        end
      end
    end
  end

  initial begin : stimulus
    step_t       s;
    key_t        k;
    mode_e       op;
    int unsigned pick;
    int unsigned i;
    int unsigned r;

    for (i = 0; i < CAPACITY; i++) tbl_state[i] = ST_EMPTY;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table. The block clears its slot states after reset; the first
    // request simply waits for in_ready_o.
    // Decrement on an empty table: not found.
    plan_step(MODE_DEC, 64'd0, 1, 1'b0, 1'b1, 16'd0, RES_NOT_FOUND);
    // Lowest and highest keys; the highest lands in the last slot.
    plan_step(MODE_INC, 64'd0, 1, 1'b0, 1'b1, 16'd1, RES_OK);
    plan_step(MODE_INC, KEY_MAX, 1, 1'b0, 1'b1, 16'd1, RES_OK);
    plan_step(MODE_INC, KEY_MAX, 1, 1'b0, 1'b1, 16'd2, RES_OK);
    // Collide on slot 0, then collide on the last slot and wrap to the front.
    plan_step(MODE_INC, 64'd1024, 1, 1'b0, 1'b0, '0, RES_OK);
    plan_step(MODE_INC, 64'd1023, 1, 1'b0, 1'b0, '0, RES_OK);
    // Kill key 0: slot 0 turns into a tombstone.
    plan_step(MODE_DEC, 64'd0, 1, 1'b0, 1'b1, 16'd0, RES_OK);
    // Find a key behind the tombstone, then reuse the tombstone for a new key.
    plan_step(MODE_INC, 64'd1023, 1, 1'b0, 1'b0, '0, RES_OK);
    plan_step(MODE_INC, 64'd2048, 1, 1'b0, 1'b0, '0, RES_OK);
    // Drain the highest key to zero, then miss it past its own tombstone.
    plan_step(MODE_DEC, KEY_MAX, 2, 1'b0, 1'b0, '0, RES_OK);
    plan_step(MODE_DEC, KEY_MAX, 1, 1'b0, 1'b1, 16'd0, RES_NOT_FOUND);
    // Fill every slot; the last few inserts already find the table full.
    plan_step(MODE_INC, FILL_BASE, CAPACITY, 1'b1, 1'b0, '0, RES_OK);
    plan_step(MODE_INC, FILL_BASE + 2000, 1, 1'b0, 1'b1, 16'd0, RES_FULL);
    // Free one slot; a new key probes a full lap and takes that tombstone.
    plan_step(MODE_DEC, FILL_BASE + 5, 1, 1'b0, 1'b1, 16'd0, RES_OK);
    plan_step(MODE_INC, FILL_BASE + 2000, 1, 1'b0, 1'b1, 16'd1, RES_OK);
    // Miss after a full lap with no empty slot, then fill again: full.
    plan_step(MODE_DEC, FILL_BASE + 3000, 1, 1'b0, 1'b1, 16'd0, RES_NOT_FOUND);
    plan_step(MODE_INC, FILL_BASE + 5, 1, 1'b0, 1'b1, 16'd0, RES_FULL);

    foreach (plan[j]) begin
      s = plan[j];
      k = s.key;
      for (r = 0; r < s.reps; r++) begin
        issue(s.op, k, s.typed, s.count, s.status);
        if (s.sweep) k = k + 1'b1;
      end
    end

    // Hot keys: random upper bits, homes in the same band as the fill keys
    // below, so they fight for the tombstones those leave behind.
    for (i = 0; i < HOT_KEYS; i++) begin
      hot_keys[i] = {$urandom(), $urandom()};
      hot_keys[i][IDX_W-1:0] = idx_t'($urandom_range(0, HOME_BAND));
    end

    // Random part. The table starts full, so most absent keys probe a whole lap;
    // keep those to a modest share and work mostly on keys that are present.
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        snd_idle_pct = 50;
        rcv_idle_pct = 16;
      end
      if (i == 2 * RANDOM_ITEMS / 3) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      pick = $urandom_range(99);
      if (pick < 55)
        k = FILL_BASE + key_t'($urandom_range(0, HOME_BAND));
      else if (pick < 95)
        k = hot_keys[$urandom_range(0, HOT_KEYS - 1)];
      else
        k = {$urandom(), $urandom()};
      op = ($urandom_range(99) < 58) ? MODE_INC : MODE_DEC;
      issue(op, k, 1'b0, '0, RES_OK);
    end
    in_valid_i <= 1'b0;

    // Wait for every awaited result, then watch a while for stray ones.
    while (awaited_tallies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fails == 0) begin
      $display("hashed_occurrence_counter regression: pass");
    end else begin
      $display("hashed_occurrence_counter regression: fail");
    end
    $finish;
  end

  // End a hung run.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("hashed_occurrence_counter regression: fail");
    $finish;
  end

endmodule
